/* sv/shrd_pkg.sv */
`timescale 1ns / 1ps

package shrd_pkg;

  // Frame delimiter and record kinds
  localparam logic [7:0] DELIM     = 8'h7E;
  localparam logic [7:0] KIND_CAP  = 8'd184;
  localparam logic [7:0] KIND_CUR  = 8'd185;
  localparam logic [7:0] KIND_VOLT = 8'd186;
  localparam logic [7:0] KIND_TEMP = 8'd103;

  // Frames shorter than this are reported as short
  localparam int unsigned MIN_FRAME = 8;

  // Frame parser phases
  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_LEN_HI  = 3'd1;
  localparam logic [2:0] PH_LEN_LO  = 3'd2;
  localparam logic [2:0] PH_TYPE    = 3'd3;
  localparam logic [2:0] PH_FLAG    = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_CHECK   = 3'd6;
  localparam logic [2:0] PH_DONE    = 3'd7;

  // Checksum verdict
  localparam logic [1:0] VERDICT_NONE = 2'd0;
  localparam logic [1:0] VERDICT_GOOD = 2'd1;
  localparam logic [1:0] VERDICT_BAD  = 2'd2;

  // Position inside a record
  localparam logic [1:0] REC_ID   = 2'd0;
  localparam logic [1:0] REC_KIND = 2'd1;
  localparam logic [1:0] REC_LOW  = 2'd2;
  localparam logic [1:0] REC_HIGH = 2'd3;

  // Bits of the held valid mask
  localparam logic [1:0] V_SOC  = 2'd0;
  localparam logic [1:0] V_CUR  = 2'd1;
  localparam logic [1:0] V_VOLT = 2'd2;
  localparam logic [1:0] V_TEMP = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_FRAME = 3'd2;
  localparam logic [2:0] ST_BAD_CSUM  = 3'd3;
  localparam logic [2:0] ST_NO_REC    = 3'd4;

  // Result item, first field in the highest bits
  typedef struct packed {
    logic [15:0] temp_value;
    logic        temp_valid;
    logic [15:0] voltage_value;
    logic        voltage_valid;
    logic [15:0] current_value;
    logic        current_valid;
    logic [7:0]  soc_percent;
    logic        soc_valid;
    logic [2:0]  status;
  } result_t;

  // Number of set bits in a byte
  function automatic logic [3:0] popcount8(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 0; k < 8; k++) begin
      n = n + {3'd0, b[k]};
    end
    return n;
  endfunction

endpackage

/* sv/sensor_hub_reply_decoder_core.sv */
`timescale 1ns / 1ps

// The result of a frame is registered and appears on m_tdata in the cycle after its last byte is taken.
// Throughput: one byte per cycle while s_tready is high; each byte passes one logic stage into the parser state.
// The result register frees s_tready whenever it is empty or being drained.
// Reset (rst, synchronous, active high) returns the parser to delimiter hunt
// and empties the result register.
module sensor_hub_reply_decoder_core #(
  parameter int unsigned MAX_FRAME  = 96,
  parameter int unsigned HUB_HEADER = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] status, [3] soc_valid, [11:4] soc_percent, [12] current_valid,
  // [28:13] current_value, [29] voltage_valid, [45:30] voltage_value,
  // [46] temp_valid, [62:47] temp_value, [63] zero
  output logic [63:0] m_tdata
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);

  // Parser state
  logic [2:0]       phase, phase_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [15:0]      body_len, body_len_next;
  logic [15:0]      payload_position, payload_position_next;
  logic [7:0]       checksum_sum, checksum_sum_next;
  logic [1:0]       checksum_verdict, checksum_verdict_next;
  logic [1:0]       record_position, record_position_next;
  logic [7:0]       record_kind, record_kind_next;
  logic [7:0]       value_low, value_low_next;
  logic             records_stopped, records_stopped_next;
  logic [7:0]       held_soc, held_soc_next;
  logic [15:0]      held_current, held_current_next;
  logic [15:0]      held_voltage, held_voltage_next;
  logic [15:0]      held_temp, held_temp_next;
  logic [3:0]       held_valid, held_valid_next;

  shrd_pkg::result_t result, result_next;
  logic              in_acc;
  logic [7:0]        b;
  logic [7:0]        csum_add;
  logic [15:0]       word;
  logic [2:0]        status_next;

  assign s_tready = !m_tvalid || m_tready;
  assign in_acc   = s_tvalid && s_tready;
  assign b        = s_tdata;
  assign csum_add = checksum_sum + {4'd0, shrd_pkg::popcount8(b)};
  assign word     = {b, value_low};
  assign m_tdata  = {1'b0, result};

  // Next parser state for the byte at the input
  always_comb begin
    phase_next            = phase;
    byte_count_next       = byte_count;
    body_len_next         = body_len;
    payload_position_next = payload_position;
    checksum_sum_next     = checksum_sum;
    checksum_verdict_next = checksum_verdict;
    record_position_next  = record_position;
    record_kind_next      = record_kind;
    value_low_next        = value_low;
    records_stopped_next  = records_stopped;
    held_soc_next         = held_soc;
    held_current_next     = held_current;
    held_voltage_next     = held_voltage;
    held_temp_next        = held_temp;
    held_valid_next       = held_valid;

    if (byte_count < CNT_W'(MAX_FRAME)) begin
      byte_count_next = byte_count + CNT_W'(1);
      unique case (phase)
        shrd_pkg::PH_HUNT: begin
          if (b == shrd_pkg::DELIM) phase_next = shrd_pkg::PH_LEN_HI;
        end
        shrd_pkg::PH_LEN_HI: begin
          body_len_next = {b, 8'd0};
          phase_next    = shrd_pkg::PH_LEN_LO;
        end
        shrd_pkg::PH_LEN_LO: begin
          body_len_next = {body_len[15:8], b};
          phase_next    = shrd_pkg::PH_TYPE;
        end
        shrd_pkg::PH_TYPE: begin
          checksum_sum_next = {4'd0, shrd_pkg::popcount8(b)};
          phase_next        = shrd_pkg::PH_FLAG;
        end
        shrd_pkg::PH_FLAG: begin
          checksum_sum_next     = csum_add;
          payload_position_next = 16'd0;
          phase_next = (body_len == 16'd0) ? shrd_pkg::PH_CHECK : shrd_pkg::PH_PAYLOAD;
        end
        shrd_pkg::PH_PAYLOAD: begin
          checksum_sum_next = csum_add;
          // record decoding past the hub header
          if (!records_stopped && payload_position >= 16'(HUB_HEADER)) begin
            unique case (record_position)
              shrd_pkg::REC_ID: record_position_next = shrd_pkg::REC_KIND;
              shrd_pkg::REC_KIND: begin
                if (b == shrd_pkg::KIND_CAP || b == shrd_pkg::KIND_CUR ||
                    b == shrd_pkg::KIND_VOLT || b == shrd_pkg::KIND_TEMP) begin
                  record_kind_next     = b;
                  record_position_next = shrd_pkg::REC_LOW;
                end else begin
                  records_stopped_next = 1'b1;
                end
              end
              shrd_pkg::REC_LOW: begin
                if (record_kind == shrd_pkg::KIND_CAP) begin
                  held_soc_next                     = b;
                  held_valid_next[shrd_pkg::V_SOC]  = 1'b1;
                  record_position_next              = shrd_pkg::REC_ID;
                end else begin
                  value_low_next       = b;
                  record_position_next = shrd_pkg::REC_HIGH;
                end
              end
              shrd_pkg::REC_HIGH: begin
                priority if (record_kind == shrd_pkg::KIND_CUR) begin
                  held_current_next                = word;
                  held_valid_next[shrd_pkg::V_CUR] = 1'b1;
                end else if (record_kind == shrd_pkg::KIND_VOLT) begin
                  held_voltage_next                 = word;
                  held_valid_next[shrd_pkg::V_VOLT] = 1'b1;
                end else begin
                  held_temp_next                    = word;
                  held_valid_next[shrd_pkg::V_TEMP] = 1'b1;
                end
                record_position_next = shrd_pkg::REC_ID;
              end
              default: record_position_next = shrd_pkg::REC_ID;
            endcase
          end
          payload_position_next = payload_position + 16'd1;
          if (payload_position + 16'd1 >= body_len) phase_next = shrd_pkg::PH_CHECK;
        end
        shrd_pkg::PH_CHECK: begin
          checksum_verdict_next = (b == checksum_sum) ? shrd_pkg::VERDICT_GOOD
                                                      : shrd_pkg::VERDICT_BAD;
          phase_next            = shrd_pkg::PH_DONE;
        end
        default: ;
      endcase
    end
  end

  // Frame verdict and gated result fields
  always_comb begin
    priority if (byte_count_next < CNT_W'(shrd_pkg::MIN_FRAME))
      status_next = shrd_pkg::ST_SHORT;
    else if (checksum_verdict_next == shrd_pkg::VERDICT_NONE)
      status_next = shrd_pkg::ST_BAD_FRAME;
    else if (checksum_verdict_next == shrd_pkg::VERDICT_BAD)
      status_next = shrd_pkg::ST_BAD_CSUM;
    else if (held_valid_next != 4'd0)
      status_next = shrd_pkg::ST_OK;
    else
      status_next = shrd_pkg::ST_NO_REC;

    result_next               = '0;
    result_next.status        = status_next;
    if (status_next == shrd_pkg::ST_OK) begin
      result_next.soc_valid     = held_valid_next[shrd_pkg::V_SOC];
      result_next.soc_percent   = held_valid_next[shrd_pkg::V_SOC] ? held_soc_next : 8'd0;
      result_next.current_valid = held_valid_next[shrd_pkg::V_CUR];
      result_next.current_value = held_valid_next[shrd_pkg::V_CUR] ? held_current_next : 16'd0;
      result_next.voltage_valid = held_valid_next[shrd_pkg::V_VOLT];
      result_next.voltage_value = held_valid_next[shrd_pkg::V_VOLT] ? held_voltage_next : 16'd0;
      result_next.temp_valid    = held_valid_next[shrd_pkg::V_TEMP];
      result_next.temp_value    = held_valid_next[shrd_pkg::V_TEMP] ? held_temp_next : 16'd0;
    end
  end

  // Control state; a last byte clears the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= shrd_pkg::PH_HUNT;
      byte_count       <= '0;
      checksum_verdict <= shrd_pkg::VERDICT_NONE;
      record_position  <= shrd_pkg::REC_ID;
      records_stopped  <= 1'b0;
      held_valid       <= 4'd0;
    end else if (in_acc) begin
      if (s_tlast) begin
        phase            <= shrd_pkg::PH_HUNT;
        byte_count       <= '0;
        checksum_verdict <= shrd_pkg::VERDICT_NONE;
        record_position  <= shrd_pkg::REC_ID;
        records_stopped  <= 1'b0;
        held_valid       <= 4'd0;
      end else begin
        phase            <= phase_next;
        byte_count       <= byte_count_next;
        checksum_verdict <= checksum_verdict_next;
        record_position  <= record_position_next;
        records_stopped  <= records_stopped_next;
        held_valid       <= held_valid_next;
      end
    end
  end

  // Data state, qualified by the control state above
  always_ff @(posedge clk) begin
    if (in_acc) begin
      body_len         <= body_len_next;
      payload_position <= payload_position_next;
      checksum_sum     <= checksum_sum_next;
      record_kind      <= record_kind_next;
      value_low        <= value_low_next;
      held_soc         <= held_soc_next;
      held_current     <= held_current_next;
      held_voltage     <= held_voltage_next;
      held_temp        <= held_temp_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_acc && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && s_tlast) result <= result_next;
  end

`ifndef SYNTH
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> m_tvalid)
    else $error("frame end did not load a result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tlast && !m_tvalid |=> !m_tvalid)
    else $error("result appeared without a frame end");

  a_valid_only_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.status != shrd_pkg::ST_OK |->
      !result.soc_valid && !result.current_valid && !result.voltage_valid &&
      !result.temp_valid)
    else $error("value marked valid on a failed frame");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_W'(MAX_FRAME))
    else $error("byte count past frame limit");

  a_ok_has_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.status == shrd_pkg::ST_OK |->
      result.soc_valid || result.current_valid || result.voltage_valid || result.temp_valid)
    else $error("ok status without any value");
`endif

endmodule
